// ===== src/ring_buffer_deque_unit_defines.svh =====
// Assertion macros for the deque RTL.
// Depends on: nothing; users must have clk and rst in scope.
`ifndef RING_BUFFER_DEQUE_UNIT_DEFINES_SVH
`define RING_BUFFER_DEQUE_UNIT_DEFINES_SVH

// Expression must hold at every clock edge outside reset.
`define RBD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next one.
`define RBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rbd_pkg.sv =====
// Types, operation codes and status codes of the ring buffer deque.
// Depends on: nothing.
package rbd_pkg;

  localparam int RBD_DEPTH = 128;

  localparam logic [2:0] FUNC_PUSH_HEAD = 3'd0;
  localparam logic [2:0] FUNC_PUSH_TAIL = 3'd1;
  localparam logic [2:0] FUNC_POP_HEAD  = 3'd2;
  localparam logic [2:0] FUNC_POP_TAIL  = 3'd3;
  localparam logic [2:0] FUNC_PEEK_HEAD = 3'd4;
  localparam logic [2:0] FUNC_PEEK_TAIL = 3'd5;
  localparam logic [2:0] FUNC_CLEAR     = 3'd6;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic               now_empty;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;   // capture the request transaction
    logic exec;      // memory access and pointer update
    logic load_out;  // fill the result register
  } ctl_cmd_t;

endpackage

// ===== src/rbd_datapath.sv =====
// Datapath: ring store, head/count pointers, request and result registers.
// Depends on: rbd_pkg.
module rbd_datapath import rbd_pkg::*; #(
  parameter int DEPTH = RBD_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  ctl_cmd_t cmd,
  input  req_t     req,
  output rsp_t     rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  // Sums of a slot and an offset stay below twice the depth.
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] x);
    wrap = (x >= DEPTH_S) ? AW'(x - DEPTH_S) : x[AW-1:0];
  endfunction

  req_t               item;
  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_word;
  logic               rd_hit;
  logic [1:0]         status;

  logic [SW-1:0] head_s;
  logic [SW-1:0] count_s;
  logic          ring_empty;
  logic          is_full;
  logic [AW-1:0] tail_slot;
  logic [AW-1:0] back_slot;
  logic [AW-1:0] prev_head;
  logic [AW-1:0] succ_head;
  logic          do_write;
  logic          do_read;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count_next;
  logic [1:0]    status_next;

  assign head_s     = {1'b0, head};
  assign count_s    = SW'(count);
  assign ring_empty = (count == '0);
  assign is_full    = (count == DEPTH_C);
  assign tail_slot  = wrap(head_s + count_s);
  assign back_slot  = wrap(head_s + count_s - SW'(1));
  assign prev_head  = (head == '0) ? LAST_SLOT : head - AW'(1);
  assign succ_head  = wrap(head_s + SW'(1));

  always_comb begin
    do_write    = 1'b0;
    do_read     = 1'b0;
    wr_addr     = head;
    rd_addr     = head;
    head_next   = head;
    count_next  = count;
    status_next = STATUS_DONE;
    case (item.func) inside
      FUNC_PUSH_HEAD: begin
        if (is_full) begin
          status_next = STATUS_FULL;
        end else begin
          do_write   = 1'b1;
          wr_addr    = prev_head;
          head_next  = prev_head;
          count_next = count + CW'(1);
        end
      end
      FUNC_PUSH_TAIL: begin
        if (is_full) begin
          status_next = STATUS_FULL;
        end else begin
          do_write   = 1'b1;
          wr_addr    = tail_slot;
          count_next = count + CW'(1);
        end
      end
      FUNC_POP_HEAD, FUNC_PEEK_HEAD: begin
        if (ring_empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          do_read = 1'b1;
          rd_addr = head;
          if (item.func == FUNC_POP_HEAD) begin
            head_next  = succ_head;
            count_next = count - CW'(1);
          end
        end
      end
      FUNC_POP_TAIL, FUNC_PEEK_TAIL: begin
        if (ring_empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          do_read = 1'b1;
          rd_addr = back_slot;
          if (item.func == FUNC_POP_TAIL) begin
            count_next = count - CW'(1);
          end
        end
      end
      FUNC_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item <= req;
    end
    if (cmd.exec) begin
      status <= status_next;
      rd_hit <= do_read;
    end
    // count already holds the post-operation value here
    if (cmd.load_out) begin
      rsp.read_value <= rd_hit ? rd_word : '0;
      rsp.status     <= status;
      rsp.now_empty  <= ring_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_write) begin
      mem[wr_addr] <= item.push_value;
    end
    if (cmd.exec && do_read) begin
      rd_word <= mem[rd_addr];
    end
  end

endmodule

// ===== src/rbd_ctrl.sv =====
// Controller: sequences accept, store access and result capture.
// Depends on: rbd_pkg, ring_buffer_deque_unit_defines.svh.
`include "ring_buffer_deque_unit_defines.svh"

module rbd_ctrl import rbd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output ctl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_ACCESS  = 2'd1;
  localparam logic [1:0] ST_CAPTURE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd.load_in  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd.exec   = 1'b1;
        state_next = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // A pending result is never overwritten.
  `RBD_ASSERT_ALWAYS(a_no_overwrite, !cmd.load_out || out_free, "result overwritten")
  `RBD_ASSERT_NEXT(a_accept_access, req_valid && !req_stall, state == ST_ACCESS,
                   "accepted transaction did not reach store access")
  `RBD_ASSERT_NEXT(a_exec_capture, cmd.exec, state == ST_CAPTURE && !cmd.exec,
                   "store access not followed by capture")
  `RBD_ASSERT_NEXT(a_load_valid, cmd.load_out, rsp_valid, "loaded result not presented")

endmodule

// ===== src/ring_buffer_deque_unit.sv =====
// Top level of the ring buffer double-ended queue.
// Depends on: rbd_pkg, rbd_ctrl, rbd_datapath.
//
//   channel   dir  handshake             payload
//   request   in   req_valid/req_stall   req (func, push_value)
//   response  out  rsp_valid/rsp_stall   rsp (read_value, status, now_empty)
//
// Each operation passes in order through accept, store access and result capture.
// The store has registered read data, so store access is a step of its own.
// In the datapath, reset clears head and count only; store contents are undefined until pushed.
// A stalled result holds in its register; the next request is taken meanwhile
// and waits in capture until the result register frees up.
module ring_buffer_deque_unit import rbd_pkg::*; #(
  parameter int DEPTH = RBD_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  ctl_cmd_t cmd;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  rbd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule
